// ===== design/miu_pkg.sv =====
package miu_pkg;

   // Width of the value, the modulus and the inverse.
   localparam int WIDTH = 31;
   // Signed width of the Bezout coefficients; their magnitude never exceeds the modulus.
   localparam int COEF_W = WIDTH + 2;
   // Width of the quotient bit counter of the restoring divider.
   localparam int CNT_W = $clog2(WIDTH);
   // Configuration port geometry.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic [ADDR_W-1:0] ADDR_MODULUS = ADDR_W'(0);
   localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(29);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic r1_zero;
   } status_type;

endpackage

// ===== design/miu_ctrl.sv =====
module miu_ctrl
   import miu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.r1_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_TEST;
         end
         ST_FINISH: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/miu_datapath.sv =====
module miu_datapath
   import miu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [WIDTH-1:0] value,
   input  logic [WIDTH-1:0] modulus,
   output status_type       status,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_inverse_value,
   output logic             rsp_exists
);

   logic [WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in, n_ff, n_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in, rem_ff, rem_in;
   logic signed [COEF_W-1:0] s0_ff, s0_in, s1_ff, s1_in, acc_ff, acc_in;
   logic valid_ff;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic exists_ff, exists_in;

   logic [WIDTH:0] rem_sh, rem_sub;
   logic           ge;
   logic signed [COEF_W-1:0] mag;
   logic [WIDTH:0] coef_lo, mag_lo, n_ext;

   // One restoring division step; the product q * s1 builds up MSB first alongside.
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[WIDTH-1]};
      rem_sub = rem_sh - {1'b0, r1_ff};
      ge      = rem_sh >= {1'b0, r1_ff};
   end

   always_comb begin
      r0_in  = r0_ff;
      r1_in  = r1_ff;
      n_in   = n_ff;
      s0_in  = s0_ff;
      s1_in  = s1_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         r0_in = value;
         r1_in = modulus;
         n_in  = modulus;
         s0_in = COEF_W'(1);
         s1_in = '0;
      end
      if (cmd.div_init) begin
         dvd_in = r0_ff;
         rem_in = '0;
         acc_in = '0;
      end
      if (cmd.div_step) begin
         dvd_in = dvd_ff << 1;
         rem_in = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
         acc_in = (acc_ff <<< 1) + (ge ? s1_ff : COEF_W'(0));
      end
      if (cmd.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         s0_in = s1_ff;
         s1_in = s0_ff - acc_ff;
      end
   end

   // Non-negative residue of the final coefficient; its magnitude is at most the modulus.
   always_comb begin
      mag     = -s0_ff;
      coef_lo = s0_ff[WIDTH:0];
      mag_lo  = mag[WIDTH:0];
      n_ext   = {1'b0, n_ff};
      exists_in = (n_ff != '0) && (r0_ff == WIDTH'(1));
      inv_in    = '0;
      if (exists_in) begin
         if (s0_ff[COEF_W-1]) begin
            if ((mag_lo == n_ext) || (mag_lo == '0)) begin
               inv_in = '0;
            end else begin
               inv_in = n_ff - mag_lo[WIDTH-1:0];
            end
         end else if (coef_lo >= n_ext) begin
            inv_in = coef_lo[WIDTH-1:0] - n_ff;
         end else begin
            inv_in = coef_lo[WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      n_ff   <= n_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      if (cmd.emit) begin
         inv_ff    <= inv_in;
         exists_ff <= exists_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
   end

   assign status.r1_zero    = (r1_ff == '0);
   assign rsp_valid         = valid_ff;
   assign rsp_inverse_value = inv_ff;
   assign rsp_exists        = exists_ff;

endmodule

// ===== design/modular_inverse_unit_core.sv =====
// Channel   Handshake                       Payload
// request   start / busy (taken: start & !busy)   req_value
// response  rsp_valid, one cycle, no stall        rsp_inverse_value, rsp_exists
// config    APB write, pready tied high           paddr, pwdata, prdata
//
// An item runs from acceptance to its response word through a series of Euclid steps
// (at most about 46 for 31-bit operands), each in ST_TEST, ST_DIVIDE and ST_UPDATE.
// Each step is set by the bit-serial restoring divider, one quotient bit a cycle.
// Reset is synchronous and active high; it idles the controller and loads modulus 29.
// The response word is shown for one cycle; the receiver cannot hold it off.
module modular_inverse_unit_core
   import miu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [WIDTH-1:0]  req_value,
   output logic              rsp_valid,
   output logic [WIDTH-1:0]  rsp_inverse_value,
   output logic              rsp_exists,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   // The modulus register; bits above the field width in the written word are dropped.
   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic             cfg_write;

   cmd_type    cmd;
   status_type status;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      modulus_in = modulus_ff;
      if (cfg_write && (paddr == ADDR_MODULUS)) begin
         modulus_in = pwdata[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // Reads of unmapped addresses return zero.
   assign prdata = (paddr == ADDR_MODULUS) ? DATA_W'(modulus_ff) : '0;

   // The controller sequences the Euclid steps; it owns the busy flag.
   miu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // The datapath holds the remainders, the coefficients and the serial divider.
   miu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .value             (req_value),
      .modulus           (modulus_ff),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_inverse_value (rsp_inverse_value),
      .rsp_exists        (rsp_exists)
   );

   // An accepted word keeps the block busy on the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a word");

   // Every response word stands for exactly one cycle.
   a_single_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response word shown for more than one cycle");

   // With no inverse the returned value is zero.
   a_zero_without_inverse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_exists |-> rsp_inverse_value == '0)
      else $error("nonzero inverse reported without an inverse");

   // A returned inverse is fully reduced below the modulus.
   a_inverse_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exists |-> rsp_inverse_value < modulus_ff)
      else $error("inverse not reduced below the modulus");

endmodule
